// ===== rtl/segment_intersection_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the segment intersection block
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_TOP_MACROS_SVH
`define SEGMENT_INTERSECTION_TOP_MACROS_SVH

// Same-cycle implication.
`define SID_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define SID_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/sid_pkg.sv =====
// ----------------------------------------------------------------------------
// sid_pkg
// Shared types and constants of the segment intersection block.
// ----------------------------------------------------------------------------
package sid_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int Q_BITS         = 32;   // width of t_value / tau_value
  localparam int P_BITS         = 40;   // width of cross_x / cross_y
  localparam int QCELLS         = Q_BITS - 1;  // quotient bits below saturation

  // per-request flags that ride along the divider chain
  typedef struct packed {
    logic parallel;
    logic hit_s;
    logic hit_f;
    logic neg_t;
    logic neg_u;
    logic ovf_t;
    logic ovf_u;
  } sid_flags_t;

  localparam int FLAG_W = $bits(sid_flags_t);

endpackage

// ===== rtl/sid_div_cell.sv =====
// ----------------------------------------------------------------------------
// sid_div_cell
// One restoring-division step for both quotients sharing one divisor.
// ----------------------------------------------------------------------------
module sid_div_cell
  import sid_pkg::*;
#(
  parameter int DVS_W  = 2 * COORD_BITS_DEF + 3,
  parameter int REM_W  = DVS_W + Q_BITS,
  parameter int SH     = 0,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [REM_W-1:0]  rem_t_i,
  input  logic [REM_W-1:0]  rem_u_i,
  input  logic [DVS_W-1:0]  dvs_i,
  input  logic [QCELLS-1:0] q_t_i,
  input  logic [QCELLS-1:0] q_u_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [REM_W-1:0]  rem_t_o,
  output logic [REM_W-1:0]  rem_u_o,
  output logic [DVS_W-1:0]  dvs_o,
  output logic [QCELLS-1:0] q_t_o,
  output logic [QCELLS-1:0] q_u_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [REM_W-1:0] dsh;
  logic             ge_t, ge_u;

  assign dsh  = REM_W'(dvs_i) << SH;
  assign ge_t = rem_t_i >= dsh;
  assign ge_u = rem_u_i >= dsh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  // subtract where the shifted divisor fits, shift the bit into the quotient
  always_ff @(posedge clk) begin
    if (en) begin
      rem_t_o <= ge_t ? rem_t_i - dsh : rem_t_i;
      rem_u_o <= ge_u ? rem_u_i - dsh : rem_u_i;
      dvs_o   <= dvs_i;
      q_t_o   <= {q_t_i[QCELLS-2:0], ge_t};
      q_u_o   <= {q_u_i[QCELLS-2:0], ge_u};
      side_o  <= side_i;
    end
  end

endmodule

// ===== rtl/segment_intersection_top.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_top
// Segment intersection by Cramer's rule; Q16.16 t/tau, Q24.16 cross point.
// ----------------------------------------------------------------------------
// Pipeline: 5 front stages, 31 divider cells and 3 back stages from input
//   request to output valid.
// Throughput: one request per cycle while the output does not stall; the
//   divider chain of cells, one quotient bit per cell, sets the depth.
// Reset: rst_n synchronous, active low; clears all valid bits, the data path
//   holds no reset.
// ----------------------------------------------------------------------------
`include "segment_intersection_top_macros.svh"

module segment_intersection_top
  import sid_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // fields from bit 0: seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
  // seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y (COORD_BITS each)
  input  logic [8*COORD_BITS-1:0] in_tdata,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // fields from bit 0: cross_x[40], cross_y[40], t_value[32], tau_value[32]
  output logic [143:0]            out_tdata,
  // fields from bit 0: parallel, hits_second, hits_first
  output logic [2:0]              out_tuser,
  output logic                    out_tvalid,
  input  logic                    out_tready
);

  localparam int C     = COORD_BITS;
  localparam int DW    = C + 1;           // coordinate differences
  localparam int PW    = 2 * C + 2;       // products of differences
  localparam int NW    = 2 * C + 3;       // det and numerators, signed
  localparam int CW    = NW + Q_BITS;     // divider remainder
  localparam int MW    = DW + Q_BITS;     // V * t product
  localparam int SW    = ((C + FRAC_BITS > MW) ? C + FRAC_BITS : MW) + 1;
  localparam int SIDE_W = FLAG_W + 2 * C + 2 * DW;

  // Global advance: every stage moves when the output register can take data.
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------------------------------------------------------- stage 1
  // capture the end points
  logic                v1_r;
  logic signed [C-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r, dx_r, dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= in_tdata[0*C +: C];
      ay_r <= in_tdata[1*C +: C];
      bx_r <= in_tdata[2*C +: C];
      by_r <= in_tdata[3*C +: C];
      cx_r <= in_tdata[4*C +: C];
      cy_r <= in_tdata[5*C +: C];
      dx_r <= in_tdata[6*C +: C];
      dy_r <= in_tdata[7*C +: C];
    end
  end

  // ---------------------------------------------------------------- stage 2
  // V = B - A, W = C - D, E = C - A
  logic                 v2_r;
  logic signed [DW-1:0] vx2_r, vy2_r, wx2_r, wy2_r, ex2_r, ey2_r;
  logic signed [C-1:0]  ax2_r, ay2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx2_r <= DW'(bx_r) - DW'(ax_r);
      vy2_r <= DW'(by_r) - DW'(ay_r);
      wx2_r <= DW'(cx_r) - DW'(dx_r);
      wy2_r <= DW'(cy_r) - DW'(dy_r);
      ex2_r <= DW'(cx_r) - DW'(ax_r);
      ey2_r <= DW'(cy_r) - DW'(ay_r);
      ax2_r <= ax_r;
      ay2_r <= ay_r;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // the six cross products
  logic                 v3_r;
  logic signed [PW-1:0] p_vxwy_r, p_vywx_r, p_exwy_r, p_eywx_r, p_vxey_r, p_vyex_r;
  logic signed [DW-1:0] vx3_r, vy3_r;
  logic signed [C-1:0]  ax3_r, ay3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_vxwy_r <= PW'(vx2_r) * PW'(wy2_r);
      p_vywx_r <= PW'(vy2_r) * PW'(wx2_r);
      p_exwy_r <= PW'(ex2_r) * PW'(wy2_r);
      p_eywx_r <= PW'(ey2_r) * PW'(wx2_r);
      p_vxey_r <= PW'(vx2_r) * PW'(ey2_r);
      p_vyex_r <= PW'(vy2_r) * PW'(ex2_r);
      vx3_r    <= vx2_r;
      vy3_r    <= vy2_r;
      ax3_r    <= ax2_r;
      ay3_r    <= ay2_r;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // det, tnum, unum
  logic                 v4_r;
  logic signed [NW-1:0] det4_r, tnum4_r, unum4_r;
  logic signed [DW-1:0] vx4_r, vy4_r;
  logic signed [C-1:0]  ax4_r, ay4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det4_r  <= NW'(p_vxwy_r) - NW'(p_vywx_r);
      tnum4_r <= NW'(p_exwy_r) - NW'(p_eywx_r);
      unum4_r <= NW'(p_vxey_r) - NW'(p_vyex_r);
      vx4_r   <= vx3_r;
      vy4_r   <= vy3_r;
      ax4_r   <= ax3_r;
      ay4_r   <= ay3_r;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // magnitudes, exact range tests, saturation tests, divider load
  logic [NW-1:0] ud, ut, uu;
  logic          sd, st, su;
  sid_flags_t    fl5;

  assign sd = det4_r[NW-1];
  assign st = tnum4_r[NW-1];
  assign su = unum4_r[NW-1];
  assign ud = sd ? NW'(-det4_r)  : NW'(det4_r);
  assign ut = st ? NW'(-tnum4_r) : NW'(tnum4_r);
  assign uu = su ? NW'(-unum4_r) : NW'(unum4_r);

  always_comb begin
    fl5.parallel = (det4_r == '0);
    fl5.hit_f    = ((tnum4_r == '0) || (st == sd)) && (ut <= ud);
    fl5.hit_s    = ((unum4_r == '0) || (su == sd)) && (uu <= ud);
    fl5.neg_t    = st != sd;
    fl5.neg_u    = su != sd;
    // quotient reaches 2^31: num * 2^F >= den * 2^31
    fl5.ovf_t    = (CW'(ut) << FRAC_BITS) >= (CW'(ud) << (Q_BITS - 1));
    fl5.ovf_u    = (CW'(uu) << FRAC_BITS) >= (CW'(ud) << (Q_BITS - 1));
  end

  logic              v5_r;
  logic [CW-1:0]     rem_t5_r, rem_u5_r;
  logic [NW-1:0]     dvs5_r;
  logic [SIDE_W-1:0] side5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_t5_r <= CW'(ut) << FRAC_BITS;
      rem_u5_r <= CW'(uu) << FRAC_BITS;
      dvs5_r   <= ud;
      side5_r  <= {fl5, ax4_r, ay4_r, vx4_r, vy4_r};
    end
  end

  // ------------------------------------------------------------ cell chain
  // cell k resolves quotient bit QCELLS-1-k
  logic              ch_v    [QCELLS+1];
  logic [CW-1:0]     ch_rt   [QCELLS+1];
  logic [CW-1:0]     ch_ru   [QCELLS+1];
  logic [NW-1:0]     ch_dvs  [QCELLS+1];
  logic [QCELLS-1:0] ch_qt   [QCELLS+1];
  logic [QCELLS-1:0] ch_qu   [QCELLS+1];
  logic [SIDE_W-1:0] ch_side [QCELLS+1];

  assign ch_v[0]    = v5_r;
  assign ch_rt[0]   = rem_t5_r;
  assign ch_ru[0]   = rem_u5_r;
  assign ch_dvs[0]  = dvs5_r;
  assign ch_qt[0]   = '0;
  assign ch_qu[0]   = '0;
  assign ch_side[0] = side5_r;

  for (genvar k = 0; k < QCELLS; k++) begin : g_cell
    sid_div_cell #(
      .DVS_W  (NW),
      .REM_W  (CW),
      .SH     (QCELLS - 1 - k),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .vld_i   (ch_v[k]),
      .rem_t_i (ch_rt[k]),
      .rem_u_i (ch_ru[k]),
      .dvs_i   (ch_dvs[k]),
      .q_t_i   (ch_qt[k]),
      .q_u_i   (ch_qu[k]),
      .side_i  (ch_side[k]),
      .vld_o   (ch_v[k+1]),
      .rem_t_o (ch_rt[k+1]),
      .rem_u_o (ch_ru[k+1]),
      .dvs_o   (ch_dvs[k+1]),
      .q_t_o   (ch_qt[k+1]),
      .q_u_o   (ch_qu[k+1]),
      .side_o  (ch_side[k+1])
    );
  end

  // ------------------------------------------------------------ quotient stage
  // apply sign and saturation to both quotients
  sid_flags_t           flq;
  logic signed [C-1:0]  axq, ayq;
  logic signed [DW-1:0] vxq, vyq;
  logic signed [Q_BITS-1:0] tq, uq;

  assign {flq, axq, ayq, vxq, vyq} = ch_side[QCELLS];

  localparam logic signed [Q_BITS-1:0] Q_MAX = {1'b0, {(Q_BITS-1){1'b1}}};
  localparam logic signed [Q_BITS-1:0] Q_MIN = {1'b1, {(Q_BITS-1){1'b0}}};

  always_comb begin
    priority if (flq.ovf_t) begin
      tq = flq.neg_t ? Q_MIN : Q_MAX;
    end else if (flq.neg_t) begin
      tq = -$signed({1'b0, ch_qt[QCELLS]});
    end else begin
      tq = $signed({1'b0, ch_qt[QCELLS]});
    end
    priority if (flq.ovf_u) begin
      uq = flq.neg_u ? Q_MIN : Q_MAX;
    end else if (flq.neg_u) begin
      uq = -$signed({1'b0, ch_qu[QCELLS]});
    end else begin
      uq = $signed({1'b0, ch_qu[QCELLS]});
    end
  end

  logic                     vq_r;
  sid_flags_t               flq_r;
  logic signed [C-1:0]      axq_r, ayq_r;
  logic signed [DW-1:0]     vxq_r, vyq_r;
  logic signed [Q_BITS-1:0] tq_r, uq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r <= 1'b0;
    end else if (en) begin
      vq_r <= ch_v[QCELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flq_r <= flq;
      axq_r <= axq;
      ayq_r <= ayq;
      vxq_r <= vxq;
      vyq_r <= vyq;
      tq_r  <= tq;
      uq_r  <= uq;
    end
  end

  // ------------------------------------------------------------ multiply stage
  // V * t
  logic                     vm_r;
  sid_flags_t               flm_r;
  logic signed [C-1:0]      axm_r, aym_r;
  logic signed [MW-1:0]     mx_r, my_r;
  logic signed [Q_BITS-1:0] tm_r, um_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (en) begin
      vm_r <= vq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flm_r <= flq_r;
      axm_r <= axq_r;
      aym_r <= ayq_r;
      mx_r  <= MW'(vxq_r) * MW'(tq_r);
      my_r  <= MW'(vyq_r) * MW'(tq_r);
      tm_r  <= tq_r;
      um_r  <= uq_r;
    end
  end

  // ------------------------------------------------------------ output stage
  // A * 2^F + V * t, saturate to 40 bits, zero all results when parallel
  logic signed [SW-1:0]     sx, sy;
  logic signed [P_BITS-1:0] px, py;

  localparam logic signed [P_BITS-1:0] P_MAX = {1'b0, {(P_BITS-1){1'b1}}};
  localparam logic signed [P_BITS-1:0] P_MIN = {1'b1, {(P_BITS-1){1'b0}}};

  assign sx = (SW'(axm_r) <<< FRAC_BITS) + SW'(mx_r);
  assign sy = (SW'(aym_r) <<< FRAC_BITS) + SW'(my_r);

  always_comb begin
    priority if ((sx[SW-1:P_BITS-1] == '0) || (sx[SW-1:P_BITS-1] == '1)) begin
      px = sx[P_BITS-1:0];
    end else begin
      px = sx[SW-1] ? P_MIN : P_MAX;
    end
    priority if ((sy[SW-1:P_BITS-1] == '0) || (sy[SW-1:P_BITS-1] == '1)) begin
      py = sy[P_BITS-1:0];
    end else begin
      py = sy[SW-1] ? P_MIN : P_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (en) begin
      out_tvalid <= vm_r;
    end
  end

  // hold the result until the request is taken
  always_ff @(posedge clk) begin
    if (en) begin
      if (flm_r.parallel) begin
        out_tdata <= '0;
        out_tuser <= 3'b001;
      end else begin
        out_tdata <= {um_r, tm_r, py, px};
        out_tuser <= {flm_r.hit_f, flm_r.hit_s, 1'b0};
      end
    end
  end

  // ------------------------------------------------------------ assertions
  `SID_ASSERT_NOW(a_par_zero, out_tvalid && out_tuser[0], (out_tdata == '0) && (out_tuser[2:1] == 2'b00))
  `SID_ASSERT_NOW(a_ready, 1'b1, in_tready == (!out_tvalid || out_tready))
  `SID_ASSERT_NOW(a_hit_t, out_tvalid && out_tuser[2], !out_tdata[111] && (out_tdata[111:80] <= (32'd1 << FRAC_BITS)))
  `SID_ASSERT_NOW(a_hit_u, out_tvalid && out_tuser[1], !out_tdata[143] && (out_tdata[143:112] <= (32'd1 << FRAC_BITS)))

endmodule

// ===== dv/tb_segment_intersection_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_intersection_top
// Streams pairs of segments into the intersection block, predicts every
// result from the end points and checks tdata/tuser request by request.
// ----------------------------------------------------------------------------
module tb_segment_intersection_top;
  import sid_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = 39;

  typedef struct packed {
    logic [2:0]   flags;   // parallel, hits_second, hits_first from bit 0
    logic [143:0] data;    // cross_x, cross_y, t_value, tau_value from bit 0
  } isect_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [8*CB-1:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [143:0] out_tdata;
  logic [2:0] out_tuser;
  logic out_tvalid;
  logic out_tready = 1'b0;

  logic [8*CB-1:0] seg_queue[$];   // requests waiting to be driven
  isect_t expected_isect[$];       // predicted results, oldest first
  int mismatches = 0;
  bit stim_done = 0;
  bit no_idle = 0;                 // long stretch without random gaps
  bit sender_pause = 0;
  int hold_cycles = 0;             // receiver hold-off, counted below

  segment_intersection_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Q16.16 quotient num*2^FB/den, truncated toward zero, saturated to 32 bits.
  function automatic longint q_divide(longint num, longint den);
    bit neg;
    longint un, ud, qi, r, mag;
    neg = (num < 0) != (den < 0);
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    qi = un / ud;
    r = un % ud;
    if (qi >= (64'sd1 << (33 - FB))) begin
      mag = 64'sd1 << 33;
    end else begin
      mag = qi << FB;
      for (int i = FB - 1; i >= 0; i--) begin
        r = r << 1;
        if (r >= ud) begin
          r -= ud;
          mag |= 64'sd1 << i;
        end
      end
    end
    if (neg) return (mag >= (64'sd1 << 31)) ? -(64'sd1 << 31) : -mag;
    return (mag > 64'sd2147483647) ? 64'sd2147483647 : mag;
  endfunction

  function automatic bit unit_range(longint num, longint den);
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    return num >= 0 && num <= den;
  endfunction

  function automatic longint clamp40(longint v);
    longint hi;
    hi = (64'sd1 <<< 39) - 1;
    if (v > hi) return hi;
    if (v < -(hi + 1)) return -(hi + 1);
    return v;
  endfunction

  function automatic isect_t solve_crossing(logic [8*CB-1:0] pts);
    longint p[8];
    longint vx, vy, wx, wy, ex, ey, det, tnum, unum, tq, uq, px, py;
    isect_t r;
    for (int i = 0; i < 8; i++) p[i] = longint'($signed(pts[i*CB +: CB]));
    vx = p[2] - p[0];
    vy = p[3] - p[1];
    wx = p[4] - p[6];
    wy = p[5] - p[7];
    ex = p[4] - p[0];
    ey = p[5] - p[1];
    det = vx * wy - vy * wx;
    r = '0;
    if (det == 0) begin
      r.flags[0] = 1'b1;
      return r;
    end
    tnum = ex * wy - ey * wx;
    unum = vx * ey - vy * ex;
    tq = q_divide(tnum, det);
    uq = q_divide(unum, det);
    px = clamp40(p[0] * (64'sd1 << FB) + vx * tq);
    py = clamp40(p[1] * (64'sd1 << FB) + vy * tq);
    r.flags[1] = unit_range(unum, det);
    r.flags[2] = unit_range(tnum, det);
    r.data[39:0] = px[39:0];
    r.data[79:40] = py[39:0];
    r.data[111:80] = tq[31:0];
    r.data[143:112] = uq[31:0];
    return r;
  endfunction

  // Pick one coordinate: extremes often, random otherwise.
  function automatic logic [CB-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(CB-1){1'b1}}};
      1: return {1'b1, {(CB-1){1'b0}}};
      2: return '0;
      3: return CB'($urandom_range(0, 15) - 8);
      default: return CB'($urandom);
    endcase
  endfunction

  // Mostly arbitrary segments; some parallel or collinear, some sharing points.
  function automatic logic [8*CB-1:0] make_segments();
    logic [CB-1:0] c[8];
    logic [CB-1:0] k;
    for (int i = 0; i < 8; i++) c[i] = pick_coord();
    case ($urandom_range(0, 7))
      0: begin                        // CD parallel to AB
        c[6] = c[4] - (c[2] - c[0]);
        c[7] = c[5] - (c[3] - c[1]);
      end
      1: begin                        // all on one line through A
        k = CB'($urandom_range(1, 3));
        c[4] = c[0] + k * (c[2] - c[0]);
        c[5] = c[1] + k * (c[3] - c[1]);
        c[6] = c[0] - (c[2] - c[0]);
        c[7] = c[1] - (c[3] - c[1]);
      end
      2: begin                        // C on an end point
        c[4] = c[2];
        c[5] = c[3];
      end
      3: begin                        // small box, many crossings
        for (int i = 0; i < 8; i++) c[i] = CB'($urandom_range(0, 64) - 32);
      end
      default: ;
    endcase
    return {c[7], c[6], c[5], c[4], c[3], c[2], c[1], c[0]};
  endfunction

  function automatic logic [8*CB-1:0] pack8(int a, int b, int c, int d, int e, int f,
                                            int g, int h);
    logic [CB-1:0] x[8];
    x = '{a[CB-1:0], b[CB-1:0], c[CB-1:0], d[CB-1:0], e[CB-1:0], f[CB-1:0],
          g[CB-1:0], h[CB-1:0]};
    return {x[7], x[6], x[5], x[4], x[3], x[2], x[1], x[0]};
  endfunction

  // Driver: present the head of the queue, advance on each accepted request.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_isect.push_back(solve_crossing(in_tdata));
        void'(seg_queue.pop_front());
      end
      if (seg_queue.size() > 0 && !sender_pause &&
          (no_idle || $urandom_range(0, 99) >= 32)) begin
        in_tvalid <= 1'b1;
        in_tdata <= seg_queue[0];
      end else if (!(in_tvalid && !in_tready)) begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Count down the receiver hold-off.
  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    isect_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_isect.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result tuser=%h tdata=%h",
                                         out_tuser, out_tdata);
        end else begin
          want = expected_isect.pop_front();
          if (out_tuser !== want.flags || out_tdata !== want.data) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: tuser exp %h got %h, tdata exp %h got %h",
                       want.flags, out_tuser, want.data, out_tdata);
          end
        end
      end
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= no_idle || $urandom_range(0, 99) >= 32;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, parallel and degenerate, touching end points.
    seg_queue.push_back(pack8(0, 0, 0, 0, 0, 0, 0, 0));
    seg_queue.push_back(pack8(0, 0, 2, 2, 0, 2, 2, 0));
    seg_queue.push_back(pack8(0, 0, 4, 0, 4, -3, 4, 3));
    seg_queue.push_back(pack8(0, 0, 4, 0, 0, 0, 0, 3));
    seg_queue.push_back(pack8(0, 0, 1, 0, 5, -1, 5, 1));
    seg_queue.push_back(pack8(0, 0, 1, 1, 2, 2, 3, 3));
    seg_queue.push_back(pack8(0, 0, 4, 0, 0, 1, 4, 1));
    seg_queue.push_back(pack8(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    seg_queue.push_back(pack8(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768));
    seg_queue.push_back(pack8(0, 0, 1, 0, 32767, -32768, 32767, 32767));
    seg_queue.push_back(pack8(0, 0, -1, 0, -32768, 1, -32768, 0));
    seg_queue.push_back(pack8(32767, 32767, 32766, 32767, -32768, 0, -32768, 1));
    seg_queue.push_back(pack8(-32768, 0, -32767, 0, 32767, -32768, 32767, 32767));
    seg_queue.push_back(pack8(0, 0, 3, 0, 1, -1, 1, 2));
    seg_queue.push_back(pack8(0, 0, 0, 5, -1, 5, 1, 5));
    seg_queue.push_back(pack8(-1, -1, -1, -1, 5, 7, 9, 2));
    seg_queue.push_back(pack8(0, 0, 32767, 1, 0, 1, 1, 0));
    seg_queue.push_back(pack8(-1, -1, -1, -1, -1, -1, -1, -1));
    seg_queue.push_back(pack8(0, 0, 1, 3, 0, 1, 3, 0));
    seg_queue.push_back(pack8(5, 5, 1, 1, 5, 1, 1, 5));

    for (int i = 0; i < 1950; i++) seg_queue.push_back(make_segments());

    // Free-running stretch with no random gaps.
    wait (seg_queue.size() < 1500);
    no_idle = 1;
    wait (seg_queue.size() < 1200);
    no_idle = 0;

    // Receiver holds off long enough for the pipeline to back up.
    @(posedge clk);
    hold_cycles <= 200;
    wait (seg_queue.size() < 900);

    // Sender pauses until every predicted result has drained.
    sender_pause = 1;
    @(posedge clk);
    wait (!in_tvalid && expected_isect.size() == 0);
    sender_pause = 0;

    wait (seg_queue.size() == 0 && !in_tvalid);
    wait (expected_isect.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    stim_done = 1;
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Also fail when a prediction is still outstanding at the end of the drain.
  always @(posedge clk) begin
    if (stim_done && expected_isect.size() != 0) mismatches++;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sid_pkg.sv
rtl/sid_div_cell.sv
rtl/segment_intersection_top.sv
dv/tb_segment_intersection_top.sv
